>>> hdl/pwm_period_duty_meter_assert.svh
// Assertion macros for the PWM period and duty meter.
`ifndef PWM_PERIOD_DUTY_METER_ASSERT_SVH
`define PWM_PERIOD_DUTY_METER_ASSERT_SVH
`ifndef SYNTH
// Checked at every clock edge while reset is low.
`define PPDM_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
// Checked at every clock edge, reset included.
`define PPDM_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) (expr)) else $error(msg);
`else
`define PPDM_ASSERT(label, expr, msg)
`define PPDM_ASSERT_ALWAYS(label, expr, msg)
`endif
`endif

>>> hdl/ppdm_pkg.sv
// Shared types and constants of the PWM period and duty meter.
package ppdm_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;

   localparam int DIV_WIDTH      = 40;
   localparam int DIV_STEP_WIDTH = 5;

   localparam logic [19:0] US_PER_SECOND = 20'd1000000;
   localparam logic [6:0]  PERCENT_FULL  = 7'd100;

   // Quotient widths: the frequency fits 20 bits, a duty below 100 fits 7.
   localparam logic [DIV_STEP_WIDTH-1:0] FREQ_STEPS = 5'd20;
   localparam logic [DIV_STEP_WIDTH-1:0] DUTY_STEPS = 5'd7;

   typedef enum logic [1:0] {
      EDGE_NONE = 2'd0,
      EDGE_RISE = 2'd1,
      EDGE_FALL = 2'd2
   } edge_kind_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EDGE,
      S_CHECK,
      S_FREQ,
      S_DUTY,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                      start;
      logic [31:0]               divisor;
      logic [31:0]               rem_init;
      logic [DIV_WIDTH-1:0]      bits;
      logic [DIV_STEP_WIDTH-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [19:0] quotient;
   } div_rsp_type;

endpackage

>>> hdl/ppdm_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module ppdm_divider
   import ppdm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [DIV_STEP_WIDTH-1:0] count_ff, count_in;
   logic [31:0]               rem_ff, rem_in;
   logic [31:0]               divisor_ff, divisor_in;
   logic [DIV_WIDTH-1:0]      sh_ff, sh_in;

   logic [32:0] trial;
   logic [32:0] diff;
   logic        fits;

   // The partial remainder stays below the divisor, so the trial fits 33 bits.
   always_comb begin
      trial = {rem_ff, sh_ff[DIV_WIDTH-1]};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      done_in    = done_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      sh_in      = sh_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         done_in    = 1'b0;
         count_in   = div_req.steps;
         rem_in     = div_req.rem_init;
         divisor_in = div_req.divisor;
         sh_in      = div_req.bits;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[31:0] : trial[31:0];
         sh_in    = {sh_ff[DIV_WIDTH-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == DIV_STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      sh_ff      <= sh_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = sh_ff[19:0];

endmodule

>>> hdl/pwm_period_duty_meter.sv
// Top level of the PWM period and duty meter.
//
// The meter takes one item per change of a digital input: a microsecond
// timestamp and the new pin level. It finds rising and falling edges against
// the previous level, measures the rise-to-rise period (after the first rise)
// and the rise-to-fall high time (when the fall is not before the last rise),
// and answers every item with one result item carrying the held period, the
// held high time, the frequency 1000000 / period and the duty
// 100 * high / period clamped to 100; both are 0 while no period is known.
// Time differences wrap modulo 2^TIME_WIDTH before being cut to 32 bits.
// Both quotients come from one shared divider that yields one quotient bit per
// clock: 20 steps for the frequency and 7 for the duty, which is skipped when
// the high time reaches the period. An accepted item goes through edge detection,
// a check state, the frequency division, the duty division unless it is skipped,
// and a done state that registers the result once the output register is free;
// both divisions are skipped while no period is known. The input side takes one
// item at a time; a finished result waits in the output register while the next
// item is accepted.
module pwm_period_duty_meter
   import ppdm_pkg::*;
#(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // timestamp_us[31:0], level[32], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // period_us, high_us, freq_hz, duty_pct, zero fill
   output logic [1:0]  rsp_tuser   // edge_kind
);

   `include "pwm_period_duty_meter_assert.svh"

   // Differences keep at most 32 bits, fewer for a narrower time base.
   localparam int          DiffWidth = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
   localparam logic [32:0] DiffFull  = (33'd1 << DiffWidth) - 33'd1;
   localparam logic [31:0] DiffMask  = DiffFull[31:0];

   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          prev_level_ff, prev_level_in;
   logic          rise_seen_ff, rise_seen_in;
   logic [31:0]   rise_time_ff, rise_time_in;
   logic [31:0]   period_ff, period_in;
   logic [31:0]   high_ff, high_in;

   logic [31:0]   ts_ff, ts_in;
   logic          level_ff, level_in;
   edge_kind_type edge_ff, edge_in;
   logic          duty_full_ff, duty_full_in;
   logic [DIV_WIDTH-1:0] scaled_ff, scaled_in;
   logic [19:0]   freq_ff, freq_in;
   logic [6:0]    duty_ff, duty_in;

   logic [95:0]   out_data_ff, out_data_in;
   logic [1:0]    out_user_ff, out_user_in;

   logic [31:0]   elapsed;
   logic [DIV_WIDTH-1:0] high_wide;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   ppdm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign elapsed   = (ts_ff - rise_time_ff) & DiffMask;
   assign high_wide = {{(DIV_WIDTH-32){1'b0}}, high_ff};

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      prev_level_in = prev_level_ff;
      rise_seen_in  = rise_seen_ff;
      rise_time_in  = rise_time_ff;
      period_in     = period_ff;
      high_in       = high_ff;
      ts_in         = ts_ff;
      level_in      = level_ff;
      edge_in       = edge_ff;
      duty_full_in  = duty_full_ff;
      scaled_in     = scaled_ff;
      freq_in       = freq_ff;
      duty_in       = duty_ff;
      out_data_in   = out_data_ff;
      out_user_in   = out_user_ff;
      req_tready    = 1'b0;
      div_req       = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ts_in    = req_tdata[31:0];
               level_in = req_tdata[32];
               state_in = S_EDGE;
            end
         end
         S_EDGE: begin
            edge_in = EDGE_NONE;
            if (!prev_level_ff && level_ff) begin
               edge_in = EDGE_RISE;
               if (rise_seen_ff) begin
                  period_in = elapsed;
               end
               rise_time_in = ts_ff;
               rise_seen_in = 1'b1;
            end else if (prev_level_ff && !level_ff) begin
               edge_in = EDGE_FALL;
               if (ts_ff >= rise_time_ff) begin
                  high_in = elapsed;
               end
            end
            prev_level_in = level_ff;
            state_in      = S_CHECK;
         end
         S_CHECK: begin
            // 100 * high as three shifted terms.
            scaled_in    = (high_wide << 6) + (high_wide << 5) + (high_wide << 2);
            duty_full_in = high_ff >= period_ff;
            freq_in      = '0;
            duty_in      = '0;
            if (period_ff == 32'd0) begin
               state_in = S_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.divisor  = period_ff;
               div_req.rem_init = '0;
               div_req.bits     = {US_PER_SECOND, {(DIV_WIDTH-20){1'b0}}};
               div_req.steps    = FREQ_STEPS;
               state_in         = S_FREQ;
            end
         end
         S_FREQ: begin
            if (div_rsp.done) begin
               freq_in = div_rsp.quotient;
               if (duty_full_ff) begin
                  duty_in  = PERCENT_FULL;
                  state_in = S_DONE;
               end else begin
                  // high < period keeps the quotient below 100 and the
                  // upper part of the dividend below the divisor.
                  div_req.start    = 1'b1;
                  div_req.divisor  = period_ff;
                  div_req.rem_init = scaled_ff[38:7];
                  div_req.bits     = {scaled_ff[6:0], {(DIV_WIDTH-7){1'b0}}};
                  div_req.steps    = DUTY_STEPS;
                  state_in         = S_DUTY;
               end
            end
         end
         S_DUTY: begin
            if (div_rsp.done) begin
               duty_in  = div_rsp.quotient[6:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_data_in  = {5'b0, duty_ff, freq_ff, high_ff, period_ff};
               out_user_in  = edge_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_level_ff <= 1'b0;
         rise_seen_ff  <= 1'b0;
         rise_time_ff  <= '0;
         period_ff     <= '0;
         high_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_level_ff <= prev_level_in;
         rise_seen_ff  <= rise_seen_in;
         rise_time_ff  <= rise_time_in;
         period_ff     <= period_in;
         high_ff       <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff        <= ts_in;
      level_ff     <= level_in;
      edge_ff      <= edge_in;
      duty_full_ff <= duty_full_in;
      scaled_ff    <= scaled_in;
      freq_ff      <= freq_in;
      duty_ff      <= duty_in;
      out_data_ff  <= out_data_in;
      out_user_ff  <= out_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // An accepted item always moves on to edge detection.
   `PPDM_ASSERT(a_accept_to_edge, (req_tvalid && req_tready) |=> (state_ff == S_EDGE), "accepted item did not reach edge detection")
   // Once a rise has been seen the flag stays until reset.
   `PPDM_ASSERT(a_rise_seen_holds, !$fell(rise_seen_ff), "rise seen flag cleared without reset")
   // Without a period, both quotients must be zero.
   `PPDM_ASSERT(a_zero_period, (rsp_tvalid && rsp_tdata[31:0] == 32'd0) |-> (rsp_tdata[90:64] == 27'd0), "nonzero frequency or duty with zero period")
   // The divider is only started while it is idle.
   `PPDM_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")

endmodule

>>> bench/pwm_period_duty_meter_tb.sv
// Self-checking bench for the PWM period and duty meter, with random flow control.
`timescale 1ns / 100ps

module pwm_period_duty_meter_tb
   import ppdm_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 850;
   localparam int TAIL_CYCLES  = 100;

   // One input item: a timestamp and the new pin level.
   typedef struct {
      logic [31:0] stamp;
      logic        level;
      bit          drain;   // hold this item back until every result is in
   } pin_sample_type;

   // One result item, field by field.
   typedef struct packed {
      logic [31:0]   period_us;
      logic [31:0]   high_us;
      logic [19:0]   freq_hz;
      logic [6:0]    duty_pct;
      edge_kind_type edge_kind;
   } meter_reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   pin_sample_type    pending_samples[$];
   meter_reading_type expected_readings[$];
   pin_sample_type    sample_on_bus;
   meter_reading_type seen_reading;
   meter_reading_type wanted_reading;

   // The bench's own copy of the meter state.
   logic        last_level;
   logic [31:0] last_rise_us;
   logic        rise_seen;
   logic [31:0] held_period_us;
   logic [31:0] held_high_us;

   int          accepted_count = 0;
   int          queued_count = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   logic        gen_level = 1'b0;

   pwm_period_duty_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Updates the meter state for one accepted sample and returns the result
   // the block must give for it.
   function automatic meter_reading_type predict_reading(input logic [31:0] stamp,
                                                         input logic level);
      meter_reading_type r;
      logic [63:0]       ratio;
      r.edge_kind = EDGE_NONE;
      if (!last_level && level) begin
         r.edge_kind = EDGE_RISE;
         // The very first rise only marks the time; a period needs two rises.
         if (rise_seen)
            held_period_us = stamp - last_rise_us;
         last_rise_us = stamp;
         rise_seen = 1'b1;
      end else if (last_level && !level) begin
         r.edge_kind = EDGE_FALL;
         // A fall stamped before the last rise leaves the high time alone.
         if (stamp >= last_rise_us)
            held_high_us = stamp - last_rise_us;
      end
      last_level = level;
      r.period_us = held_period_us;
      r.high_us = held_high_us;
      r.freq_hz = '0;
      r.duty_pct = '0;
      if (held_period_us != 0) begin
         ratio = 64'd1000000 / {32'd0, held_period_us};
         r.freq_hz = ratio[19:0];
         ratio = (64'd100 * {32'd0, held_high_us}) / {32'd0, held_period_us};
         if (ratio > 64'd100)
            ratio = 64'd100;
         r.duty_pct = ratio[6:0];
      end
      return r;
   endfunction

   // Flow control runs in phases of 64 accepted items: none, sender idle,
   // receiver stalling, then both lightly.
   function automatic int flow_phase();
      return (accepted_count / 64) % 4;
   endfunction

   function automatic bit sender_may_go();
      int idle_pct;
      if (pending_samples[0].drain && expected_readings.size() != 0)
         return 1'b0;
      case (flow_phase())
         1: idle_pct = 55;
         3: idle_pct = 14;
         default: idle_pct = 0;
      endcase
      return $urandom_range(0, 99) >= idle_pct;
   endfunction

   function automatic int stall_pct();
      case (flow_phase())
         2: return 55;
         3: return 14;
         default: return 0;
      endcase
   endfunction

   task automatic add_sample(input logic [31:0] stamp, input logic level);
      pin_sample_type s;
      s.stamp = stamp;
      s.level = level;
      // Now and then the sender lets the meter drain completely.
      s.drain = (queued_count % 250) == 125;
      pending_samples.push_back(s);
      queued_count++;
      gen_level = level;
   endtask

   // Driver: the expectation is computed when the item is accepted, then the
   // next pending item is offered, or the bus goes idle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(predict_reading(sample_on_bus.stamp,
                                                        sample_on_bus.level));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && sender_may_go()) begin
               sample_on_bus = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {7'd0, sample_on_bus.level, sample_on_bus.stamp};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted result item is checked against the oldest
   // expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_reading.period_us = rsp_tdata[31:0];
            seen_reading.high_us = rsp_tdata[63:32];
            seen_reading.freq_hz = rsp_tdata[83:64];
            seen_reading.duty_pct = rsp_tdata[90:84];
            seen_reading.edge_kind = edge_kind_type'(rsp_tuser);
            if (expected_readings.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display({"unexpected result item:",
                            " period %0d high %0d freq %0d duty %0d edge %0d"},
                           seen_reading.period_us, seen_reading.high_us,
                           seen_reading.freq_hz, seen_reading.duty_pct,
                           seen_reading.edge_kind);
            end else begin
               wanted_reading = expected_readings.pop_front();
               if (seen_reading !== wanted_reading) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"mismatch: expected period %0d high %0d freq %0d duty %0d edge %0d,",
                               " got period %0d high %0d freq %0d duty %0d edge %0d"},
                              wanted_reading.period_us, wanted_reading.high_us,
                              wanted_reading.freq_hz, wanted_reading.duty_pct,
                              wanted_reading.edge_kind,
                              seen_reading.period_us, seen_reading.high_us,
                              seen_reading.freq_hz, seen_reading.duty_pct,
                              seen_reading.edge_kind);
               end
            end
         end
         rsp_tready <= $urandom_range(0, 99) >= stall_pct();
      end
   end

   // A hung block ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] t_us;
      logic [31:0] span_us;
      logic [31:0] high_part;
      int          pick;
      int          burst;

      last_level = 1'b0;
      last_rise_us = '0;
      rise_seen = 1'b0;
      held_period_us = '0;
      held_high_us = '0;

      // Directed part. No edge with no period yet, at both ends of the clock.
      add_sample(32'd100, 1'b0);
      add_sample(32'hFFFF_FFFF, 1'b0);
      // The first rise only stores its time, then a repeated level.
      add_sample(32'd1000, 1'b1);
      add_sample(32'd1000, 1'b1);
      // A fall while the period is still zero.
      add_sample(32'd1400, 1'b0);
      add_sample(32'd2000, 1'b1);
      add_sample(32'd2001, 1'b0);
      add_sample(32'd2002, 1'b1);
      add_sample(32'd2003, 1'b0);
      // A one microsecond period gives the top frequency; duty hits the clamp.
      add_sample(32'd2003, 1'b1);
      // A fall stamped before the last rise.
      add_sample(32'd1500, 1'b0);
      // A huge period, then a wrap of the counter between two rises.
      add_sample(32'hFFFF_FF00, 1'b1);
      add_sample(32'h0000_0100, 1'b0);
      add_sample(32'h0000_0200, 1'b1);
      // A high time far longer than the period, then a near-full duty.
      add_sample(32'h7000_0200, 1'b0);
      add_sample(32'h7000_0300, 1'b1);
      add_sample(32'h7000_0300, 1'b1);
      // A fall at the very time of the rise gives a zero high time.
      add_sample(32'h7000_0300, 1'b0);
      add_sample(32'hFFFF_FFFF, 1'b1);
      add_sample(32'hFFFF_FFFF, 1'b0);
      add_sample(32'h0000_0000, 1'b1);
      add_sample(32'h0000_0000, 1'b0);

      // Random part: mostly clean PWM bursts at a random phase of the
      // counter, the rest glitches with random times and levels.
      t_us = $urandom();
      while (queued_count < RANDOM_ITEMS + 22) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
               span_us = $urandom_range(1, 5000);
            else if (pick < 90)
               span_us = $urandom_range(1, 1 << 20);
            else
               span_us = $urandom() | 32'd1;
            high_part = $urandom_range(0, span_us);
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               add_sample(t_us, 1'b1);
               if ($urandom_range(0, 99) < 5)
                  add_sample(t_us + 32'd1, 1'b1);
               add_sample(t_us + high_part, 1'b0);
               t_us = t_us + span_us;
            end
         end else begin
            burst = $urandom_range(1, 4);
            repeat (burst) begin
               if ($urandom_range(0, 1) == 0)
                  add_sample($urandom(), 1'($urandom_range(0, 1)));
               else
                  add_sample(t_us - $urandom_range(0, 300), ~gen_level);
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Let every item go in and every result come out, then watch for strays.
      while (pending_samples.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_readings.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_readings.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
